FILE: design/psp_pkg.sv
// Shared types, codes and constants of the polyphonic slice player.
package psp_pkg;

    typedef struct packed {
        logic [2:0]         command;
        logic [6:0]         note;
        logic [6:0]         velocity;
        logic [15:0]        frame_address;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [7:0]         slice_number;
        logic [16:0]        slice_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_item;

    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON     = 3'd1;
    localparam logic [2:0] CMD_NOTE_OFF    = 3'd2;
    localparam logic [2:0] CMD_WRITE_FRAME = 3'd3;
    localparam logic [2:0] CMD_WRITE_SLICE = 3'd4;

    localparam logic [2:0] REG_RATE_STEP     = 3'd0;
    localparam logic [2:0] REG_ATTACK_COEFF  = 3'd1;
    localparam logic [2:0] REG_DECAY_COEFF   = 3'd2;
    localparam logic [2:0] REG_GAIN          = 3'd3;
    localparam logic [2:0] REG_GATE_MODE     = 3'd4;
    localparam logic [2:0] REG_SLICES_IN_USE = 3'd5;

    localparam logic [18:0] RST_RATE_STEP    = 19'd65536;
    localparam logic [24:0] RST_ATTACK_COEFF = 25'd16258620;
    localparam logic [24:0] RST_DECAY_COEFF  = 25'd16764079;
    localparam logic [15:0] RST_GAIN         = 16'd13107;

    localparam logic [24:0] Q24_ONE     = 25'd16777216;
    localparam logic [24:0] ATTACK_DONE = 25'd16760440;
    localparam logic [24:0] DECAY_FLOOR = 25'd1678;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = 2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_FRAME,
        OP_SLICE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [15:0] addr;
        logic [31:0] frame;
        logic [7:0]  slice_no;
        logic [16:0] slice_frame;
    } t_qitem;

    typedef struct packed {
        logic [18:0] rate_step;
        logic [24:0] attack_coeff;
        logic [24:0] decay_coeff;
        logic [15:0] gain;
        logic        gate_mode;
        logic [7:0]  slices_in_use;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ATTACK,
        PH_SUSTAIN,
        PH_DECAY
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_RD0,
        S_RD1,
        S_CHK,
        S_OFF,
        S_TSEL,
        S_TENV,
        S_TAMP0,
        S_TAMP1,
        S_TAMP2,
        S_TAMP3,
        S_TM0,
        S_TM1,
        S_TM2,
        S_TM3,
        S_TM4,
        S_TNEXT,
        S_TOUT
    } t_state;

    function automatic logic [24:0] clamp_one(input logic [24:0] c);
        clamp_one = (c > Q24_ONE) ? Q24_ONE : c;
    endfunction

endpackage

FILE: design/psp_front.sv
// Request intake: decodes commands, drops those with no effect, feeds the queue.
module psp_front import psp_pkg::*; #(
    parameter int SLICE_ENTRIES = 128,
    parameter int FRAME_DEPTH   = 65536
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_qitem   o_item
);

    logic r_seen;
    logic n_seen;
    logic keep;

    always_comb begin
        keep          = 1'b0;
        o_item.op     = OP_TICK;
        o_item.note   = i_data.note;
        o_item.vel    = i_data.velocity;
        o_item.addr   = i_data.frame_address;
        o_item.frame  = {i_data.right_in, i_data.left_in};
        o_item.slice_no    = i_data.slice_number;
        o_item.slice_frame = i_data.slice_frame;
        unique case (i_data.command)
            CMD_TICK: begin
                keep      = 1'b1;
                o_item.op = OP_TICK;
            end
            CMD_NOTE_ON: begin
                keep      = 1'b1;
                o_item.op = (i_data.velocity == 7'd0) ? OP_NOTE_OFF : OP_NOTE_ON;
            end
            CMD_NOTE_OFF: begin
                keep      = 1'b1;
                o_item.op = OP_NOTE_OFF;
            end
            CMD_WRITE_FRAME: begin
                keep      = (21'(i_data.frame_address) < 21'(FRAME_DEPTH));
                o_item.op = OP_FRAME;
            end
            CMD_WRITE_SLICE: begin
                keep      = (9'(i_data.slice_number) <= 9'(SLICE_ENTRIES));
                o_item.op = OP_SLICE;
            end
            default: keep = 1'b0;
        endcase
    end

    // stall held until the first clock after reset
    assign n_seen  = 1'b1;
    assign o_stall = i_full || !r_seen;
    assign o_push  = i_valid && !o_stall && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

FILE: design/psp_queue.sv
// Short request queue between intake and voice engine.
module psp_queue import psp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_qitem o_head
);

    t_qitem         r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;

    assign o_full  = (r_cnt == (QPW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPW+1)'(i_push) - (QPW+1)'(i_pop);
        end
    end

endmodule

FILE: design/psp_engine.sv
// Voice engine: sample and slice memories, voice state, note handling, tick mixing.
module psp_engine import psp_pkg::*; #(
    parameter int VOICES        = 8,
    parameter int SLICE_ENTRIES = 128,
    parameter int FRAME_DEPTH   = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_empty,
    input  t_qitem    i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int TW = $clog2(SLICE_ENTRIES + 1);
    localparam int AW = $clog2(FRAME_DEPTH);
    localparam logic [16:0] LIM = (FRAME_DEPTH < 65536) ? 17'(FRAME_DEPTH) : 17'd65536;
    localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);

    // memories
    logic [31:0] r_smem [FRAME_DEPTH];
    logic [16:0] r_stab [SLICE_ENTRIES + 1];
    logic [31:0] r_srd;
    logic [16:0] r_trd;

    // voice state
    logic [VOICES-1:0] r_act;
    logic [6:0]        r_vnote [VOICES];
    logic [32:0]       r_pos   [VOICES];
    logic [18:0]       r_vrate [VOICES];
    logic [16:0]       r_vend  [VOICES];
    t_phase            r_ph    [VOICES];
    logic [24:0]       r_lvl   [VOICES];
    logic [24:0]       r_vatk  [VOICES];
    logic [24:0]       r_vdec  [VOICES];
    logic [6:0]        r_vvel  [VOICES];

    t_state r_state, n_state;
    logic [VW-1:0] r_vi;
    logic          r_ch;
    logic [2:0]    r_k;
    logic [6:0]    r_rem;
    logic [8:0]    r_n;
    logic [6:0]    r_note;
    logic [6:0]    r_vel;
    logic [16:0]   r_start;
    logic [49:0]   r_prod;
    logic [22:0]   r_vg;
    logic [24:0]   r_env;
    logic [47:0]   r_ap;
    logic [33:0]   r_x;
    logic [26:0]   r_q;
    logic [31:0]   r_w0;
    logic signed [33:0] r_m0;
    logic signed [33:0] r_m1;
    logic [31:0]   r_mag;
    logic          r_neg;
    logic [17:0]   r_sc;
    logic signed [15:0] r_mix_l;
    logic signed [15:0] r_mix_r;
    logic          r_ov;
    t_out_item     r_out;

    // combinational
    logic          pop;
    logic [8:0]    n_eff;
    logic [14:0]   nk;
    logic          div_sub;
    logic [TW-1:0] tab_ra;
    logic          tab_re;
    logic [AW-1:0] smp_ra;
    logic          smp_re;
    logic [16:0]   clip_end;
    logic [VW-1:0] free_v;
    logic [24:0]   atk_c;
    logic [24:0]   dec_c;
    logic [24:0]   cur_lvl;
    logic [24:0]   mul_a;
    logic [24:0]   mul_b;
    logic [26:0]   ceil_step;
    logic [26:0]   att_sum;
    logic [24:0]   env_n;
    t_phase        ph_n;
    logic          act_n;
    logic          past_end;
    logic [16:0]   pi;
    logic [16:0]   pn;
    logic [33:0]   est_sum;
    logic [33:0]   rem127;
    logic signed [15:0] s0;
    logic signed [15:0] s1;
    logic signed [17:0] wt0;
    logic signed [17:0] wt1;
    logic signed [33:0] lerp;
    logic [33:0]   lerp_mag;
    logic [58:0]   sc_full;
    logic signed [18:0] sv;
    logic signed [15:0] mix_cur;
    logic signed [19:0] mix_sum;
    logic signed [15:0] mix_sat;
    logic          out_free;

    assign pop      = (r_state == S_IDLE) && !i_empty;
    assign o_pop    = pop;
    assign o_valid  = r_ov;
    assign o_data   = r_out;
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        n_eff = (9'(i_cfg.slices_in_use) > 9'(SLICE_ENTRIES)) ? 9'(SLICE_ENTRIES)
                                                               : 9'(i_cfg.slices_in_use);
        nk      = 15'(r_n) << r_k;
        div_sub = (15'(r_rem) >= nk);
        clip_end = (r_trd > LIM) ? LIM : r_trd;

        free_v = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_act[i]) begin
                free_v = VW'(i);
            end
        end

        atk_c   = clamp_one(r_vatk[r_vi]);
        dec_c   = clamp_one(r_vdec[r_vi]);
        cur_lvl = r_lvl[r_vi];
        mul_a   = (r_ph[r_vi] == PH_ATTACK) ? (Q24_ONE - cur_lvl) : cur_lvl;
        mul_b   = (r_ph[r_vi] == PH_ATTACK) ? (Q24_ONE - atk_c) : dec_c;

        ceil_step = 27'((51'(r_prod) + 51'(Q24_ONE - 25'd1)) >> 24);
        att_sum   = 27'(cur_lvl) + ceil_step;
        env_n = cur_lvl;
        ph_n  = r_ph[r_vi];
        act_n = 1'b1;
        unique case (r_ph[r_vi])
            PH_ATTACK: begin
                env_n = (atk_c == Q24_ONE) ? Q24_ONE : att_sum[24:0];
                if (atk_c == Q24_ONE || att_sum >= 27'(ATTACK_DONE)) begin
                    env_n = Q24_ONE;
                    ph_n  = i_cfg.gate_mode ? PH_SUSTAIN : PH_DECAY;
                end
            end
            PH_SUSTAIN: env_n = Q24_ONE;
            PH_DECAY: begin
                env_n = r_prod[48:24];
                if (r_prod[48:24] < DECAY_FLOOR) begin
                    env_n = '0;
                    ph_n  = PH_IDLE;
                    act_n = 1'b0;
                end
            end
            PH_IDLE: act_n = 1'b0;
        endcase

        past_end = (r_pos[r_vi][32:16] >= r_vend[r_vi]);
        pi = r_pos[r_vi][32:16];
        pn = pi + 17'd1;
        if (pn >= r_vend[r_vi]) begin
            pn = r_vend[r_vi] - 17'd1;
        end

        est_sum = r_x + (r_x >> 7) + (r_x >> 14) + (r_x >> 21) + (r_x >> 28);
        rem127  = r_x - ((34'(r_q) << 7) - 34'(r_q));

        s0  = r_ch ? $signed(r_w0[31:16]) : $signed(r_w0[15:0]);
        s1  = r_ch ? $signed(r_srd[31:16]) : $signed(r_srd[15:0]);
        wt0 = $signed({1'b0, 17'(17'd65536 - 17'(r_pos[r_vi][15:0]))});
        wt1 = $signed({2'b00, r_pos[r_vi][15:0]});
        lerp     = r_m0 + r_m1;
        lerp_mag = lerp[33] ? 34'(-lerp) : 34'(lerp);
        sc_full  = 59'(r_mag) * 59'(r_q);
        sv       = r_neg ? -$signed({1'b0, r_sc}) : $signed({1'b0, r_sc});
        mix_cur  = r_ch ? r_mix_r : r_mix_l;
        mix_sum  = {{4{mix_cur[15]}}, mix_cur} + {sv[18], sv};
        if (mix_sum > 20'sd32767) begin
            mix_sat = 16'sd32767;
        end else if (mix_sum < -20'sd32768) begin
            mix_sat = -16'sd32768;
        end else begin
            mix_sat = mix_sum[15:0];
        end

        tab_re = (r_state == S_RD0) || (r_state == S_RD1);
        tab_ra = (r_state == S_RD1) ? (TW'(r_rem) + TW'(1)) : TW'(r_rem);
        smp_re = (r_state == S_TAMP0) || (r_state == S_TAMP1);
        smp_ra = (r_state == S_TAMP1) ? AW'(pn) : AW'(pi);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_head.op)
                        OP_TICK:     n_state = S_TSEL;
                        OP_NOTE_ON:  n_state = (n_eff != 9'd0) ? S_DIV : S_IDLE;
                        OP_NOTE_OFF: n_state = i_cfg.gate_mode ? S_OFF : S_IDLE;
                        OP_FRAME:    n_state = S_IDLE;
                        OP_SLICE:    n_state = S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:   n_state = (r_k == 3'd0) ? S_RD0 : S_DIV;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_CHK;
            S_CHK:   n_state = S_IDLE;
            S_OFF: begin
                if ((r_act[r_vi] && r_vnote[r_vi] == r_note) || r_vi == LAST_V) begin
                    n_state = S_IDLE;
                end
            end
            S_TSEL:  n_state = r_act[r_vi] ? S_TENV : S_TNEXT;
            S_TENV:  n_state = (!act_n || past_end) ? S_TNEXT : S_TAMP0;
            S_TAMP0: n_state = S_TAMP1;
            S_TAMP1: n_state = S_TAMP2;
            S_TAMP2: n_state = S_TAMP3;
            S_TAMP3: n_state = (rem127 >= 34'd127) ? S_TAMP3 : S_TM0;
            S_TM0:   n_state = S_TM1;
            S_TM1:   n_state = S_TM2;
            S_TM2:   n_state = S_TM3;
            S_TM3:   n_state = S_TM4;
            S_TM4:   n_state = r_ch ? S_TNEXT : S_TM0;
            S_TNEXT: n_state = (r_vi == LAST_V) ? S_TOUT : S_TSEL;
            S_TOUT:  n_state = out_free ? S_IDLE : S_TOUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_head.op == OP_FRAME) begin
            r_smem[AW'(i_head.addr)] <= i_head.frame;
        end
        if (smp_re) begin
            r_srd <= r_smem[smp_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_head.op == OP_SLICE) begin
            r_stab[TW'(i_head.slice_no)] <= i_head.slice_frame;
        end
        if (tab_re) begin
            r_trd <= r_stab[tab_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_act <= '0;
            r_vi  <= '0;
            for (int i = 0; i < VOICES; i++) begin
                r_ph[i] <= PH_IDLE;
            end
        end else begin
            if (r_state == S_TOUT && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_note  <= i_head.note;
                        r_vel   <= i_head.vel;
                        r_n     <= n_eff;
                        r_rem   <= i_head.note;
                        r_k     <= 3'd6;
                        r_vi    <= '0;
                        r_mix_l <= '0;
                        r_mix_r <= '0;
                    end
                end
                S_DIV: begin
                    if (div_sub) begin
                        r_rem <= r_rem - nk[6:0];
                    end
                    r_k <= r_k - 3'd1;
                end
                S_RD0: ;
                S_RD1: r_start <= r_trd;
                S_CHK: begin
                    if (clip_end > r_start) begin
                        r_act[free_v]   <= 1'b1;
                        r_vnote[free_v] <= r_note;
                        r_pos[free_v]   <= {r_start, 16'h0000};
                        r_vrate[free_v] <= i_cfg.rate_step;
                        r_vend[free_v]  <= clip_end;
                        r_ph[free_v]    <= PH_ATTACK;
                        r_lvl[free_v]   <= '0;
                        r_vatk[free_v]  <= i_cfg.attack_coeff;
                        r_vdec[free_v]  <= i_cfg.decay_coeff;
                        r_vvel[free_v]  <= r_vel;
                    end
                end
                S_OFF: begin
                    if (r_act[r_vi] && r_vnote[r_vi] == r_note) begin
                        if (r_ph[r_vi] != PH_IDLE) begin
                            r_ph[r_vi] <= PH_DECAY;
                        end
                    end else if (r_vi != LAST_V) begin
                        r_vi <= r_vi + VW'(1);
                    end
                end
                S_TSEL: begin
                    r_prod <= 50'(mul_a) * 50'(mul_b);
                    r_vg   <= 23'(r_vvel[r_vi]) * 23'(i_cfg.gain);
                end
                S_TENV: begin
                    r_lvl[r_vi] <= env_n;
                    r_env       <= env_n;
                    if (!act_n || past_end) begin
                        r_ph[r_vi]  <= PH_IDLE;
                        r_act[r_vi] <= 1'b0;
                    end else begin
                        r_ph[r_vi] <= ph_n;
                    end
                end
                S_TAMP0: r_ap <= 48'(r_vg) * 48'(r_env);
                S_TAMP1: begin
                    r_x  <= 34'(r_ap >> 14);
                    r_w0 <= r_srd;
                end
                S_TAMP2: r_q <= est_sum[33:7];
                S_TAMP3: begin
                    if (rem127 >= 34'd127) begin
                        r_q <= r_q + 27'd1;
                    end
                    r_ch <= 1'b0;
                end
                S_TM0:   r_m0 <= s0 * wt0;
                S_TM1:   r_m1 <= s1 * wt1;
                S_TM2: begin
                    r_neg <= lerp[33];
                    r_mag <= lerp_mag[31:0];
                end
                S_TM3:   r_sc <= sc_full[57:40];
                S_TM4: begin
                    if (r_ch) begin
                        r_mix_r     <= mix_sat;
                        r_pos[r_vi] <= r_pos[r_vi] + 33'(r_vrate[r_vi]);
                    end else begin
                        r_mix_l <= mix_sat;
                    end
                    r_ch <= 1'b1;
                end
                S_TNEXT: begin
                    if (r_vi != LAST_V) begin
                        r_vi <= r_vi + VW'(1);
                    end
                end
                S_TOUT: begin
                    if (out_free) begin
                        r_out.left_out  <= r_mix_l;
                        r_out.right_out <= r_mix_r;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: design/polyphonic_slice_player.sv
// Top level of the polyphonic slice player: register port, intake, queue and voice engine.
// Requests enter through a four-deep queue and are carried out one at a time by the voice
// engine. A note on runs a seven-step remainder unit, two slice table reads and a voice
// check; a note off in gate mode scans the voices in order until a match, up to VOICES.
// A tick steps through every voice, paced by the shared multiplier sequence and the single
// read port of the sample memory; the result waits in an output register while further
// requests are taken. The user must write registers only while the block is idle; the
// block itself does not enforce this. The register port is always ready.
module polyphonic_slice_player import psp_pkg::*; #(
    parameter int VOICES        = 8,
    parameter int SLICE_ENTRIES = 128,
    parameter int FRAME_DEPTH   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_in_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_qitem item;
    t_qitem head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_step     <= RST_RATE_STEP;
            r_cfg.attack_coeff  <= RST_ATTACK_COEFF;
            r_cfg.decay_coeff   <= RST_DECAY_COEFF;
            r_cfg.gain          <= RST_GAIN;
            r_cfg.gate_mode     <= 1'b0;
            r_cfg.slices_in_use <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_RATE_STEP:     r_cfg.rate_step     <= i_cfg_data[18:0];
                REG_ATTACK_COEFF:  r_cfg.attack_coeff  <= i_cfg_data;
                REG_DECAY_COEFF:   r_cfg.decay_coeff   <= i_cfg_data;
                REG_GAIN:          r_cfg.gain          <= i_cfg_data[15:0];
                REG_GATE_MODE:     r_cfg.gate_mode     <= i_cfg_data[0];
                REG_SLICES_IN_USE: r_cfg.slices_in_use <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    psp_front #(
        .SLICE_ENTRIES(SLICE_ENTRIES),
        .FRAME_DEPTH  (FRAME_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_item  (item)
    );

    psp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    psp_engine #(
        .VOICES       (VOICES),
        .SLICE_ENTRIES(SLICE_ENTRIES),
        .FRAME_DEPTH  (FRAME_DEPTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_out_data)
    );

endmodule

FILE: design/psp_checker.sv
// Port-level checks for the polyphonic slice player, bound to the top level.
module psp_checker import psp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input t_out_item   o_out_data,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("intake open during reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("register port not ready");

endmodule

bind polyphonic_slice_player psp_checker u_psp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

FILE: sim/tb_top.sv
// Self-checking testbench of the polyphonic slice player: queued requests, voice predictor, mix checks.
module tb_top import psp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_in_data;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [24:0] i_cfg_data;

    polyphonic_slice_player u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    t_cfg        cfg_shadow;
    logic        vc_active [8];
    logic [6:0]  vc_note [8];
    longint unsigned vc_pos [8];
    logic [18:0] vc_rate [8];
    logic [16:0] vc_end [8];
    t_phase      vc_phase [8];
    longint unsigned vc_env [8];
    logic [24:0] vc_att [8];
    logic [24:0] vc_dec [8];
    logic [6:0]  vc_vel [8];
    logic [31:0] frame_mem [65536];
    logic [16:0] slice_starts [129];

    // request generator view
    bit          gen_written [65536];
    bit          gen_slice_set [129];
    int          gen_slice [129];
    int          gen_slices_in_use;
    int          recent_notes [$];

    t_in_item    pending_requests [$];
    t_out_item   expected_mix [$];
    int          errors;
    bit          started;
    bit          quiet;
    bit          took;
    int          send_idle;
    int          recv_idle;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic int sat16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic int scale_amp(longint s, longint unsigned amp);
        longint unsigned m;
        longint r;
        m = s < 0 ? longint'(-s) : longint'(s);
        r = longint'((m * amp) >> 40);
        return int'(s < 0 ? -r : r);
    endfunction

    function automatic longint unsigned clamp_q24(logic [24:0] c);
        return c > Q24_ONE ? longint'(Q24_ONE) : longint'(c);
    endfunction

    task automatic voice_note_off(input logic [6:0] nt);
        if (!cfg_shadow.gate_mode) return;
        for (int i = 0; i < 8; i++) begin
            if (vc_active[i] && vc_note[i] == nt) begin
                if (vc_phase[i] != PH_IDLE) vc_phase[i] = PH_DECAY;
                return;
            end
        end
    endtask

    task automatic voice_note_on(input logic [6:0] nt, input logic [6:0] vel);
        int n;
        int idx;
        int s;
        int e;
        int v;
        n = cfg_shadow.slices_in_use > 128 ? 128 : cfg_shadow.slices_in_use;
        v = 0;
        if (n == 0) return;
        idx = nt % n;
        s = slice_starts[idx];
        e = slice_starts[idx + 1];
        if (e > 65536) e = 65536;
        if (e <= s) return;
        for (int i = 0; i < 8; i++) begin
            if (!vc_active[i]) begin
                v = i;
                break;
            end
        end
        vc_active[v] = 1'b1;
        vc_note[v]   = nt;
        vc_pos[v]    = longint'(s) << 16;
        vc_rate[v]   = cfg_shadow.rate_step;
        vc_end[v]    = e[16:0];
        vc_phase[v]  = PH_ATTACK;
        vc_env[v]    = 0;
        vc_att[v]    = cfg_shadow.attack_coeff;
        vc_dec[v]    = cfg_shadow.decay_coeff;
        vc_vel[v]    = vel;
    endtask

    function automatic t_out_item render_tick();
        int lm;
        int rm;
        longint unsigned one;
        longint unsigned env;
        longint unsigned a;
        longint unsigned p;
        longint unsigned amp;
        longint unsigned pi;
        longint unsigned pn;
        longint unsigned frac;
        logic [31:0] w0;
        logic [31:0] w1;
        longint l0, l1, r0, r1, ls, rs;
        t_out_item res;
        lm = 0;
        rm = 0;
        one = Q24_ONE;
        for (int i = 0; i < 8; i++) begin
            if (!vc_active[i]) continue;
            env = vc_env[i];
            case (vc_phase[i])
                PH_ATTACK: begin
                    a = clamp_q24(vc_att[i]);
                    if (a >= one) begin
                        env = one;
                    end else begin
                        p = (one - env) * (one - a);
                        env = env + ((p + one - 1) >> 24);
                    end
                    if (env >= ATTACK_DONE) begin
                        env = one;
                        vc_phase[i] = cfg_shadow.gate_mode ? PH_SUSTAIN : PH_DECAY;
                    end
                end
                PH_SUSTAIN: env = one;
                PH_DECAY: begin
                    env = (env * clamp_q24(vc_dec[i])) >> 24;
                    if (env < DECAY_FLOOR) begin
                        env = 0;
                        vc_phase[i] = PH_IDLE;
                        vc_active[i] = 1'b0;
                    end
                end
                default: vc_active[i] = 1'b0;
            endcase
            vc_env[i] = env;
            if (!vc_active[i]) continue;
            if ((vc_pos[i] >> 16) >= vc_end[i]) begin
                vc_phase[i] = PH_IDLE;
                vc_active[i] = 1'b0;
                continue;
            end
            pi = vc_pos[i] >> 16;
            frac = vc_pos[i] & 64'hFFFF;
            pn = pi + 1;
            if (pn >= vc_end[i]) pn = vc_end[i] - 1;
            w0 = frame_mem[pi[15:0]];
            w1 = frame_mem[pn[15:0]];
            l0 = signed'(w0[15:0]);
            l1 = signed'(w1[15:0]);
            r0 = signed'(w0[31:16]);
            r1 = signed'(w1[31:16]);
            ls = l0 * longint'(65536 - frac) + l1 * longint'(frac);
            rs = r0 * longint'(65536 - frac) + r1 * longint'(frac);
            amp = (longint'(vc_vel[i]) * longint'(cfg_shadow.gain) * env) / (127 * 16384);
            lm = sat16(lm + scale_amp(ls, amp));
            rm = sat16(rm + scale_amp(rs, amp));
            vc_pos[i] = vc_pos[i] + vc_rate[i];
        end
        res.left_out  = lm[15:0];
        res.right_out = rm[15:0];
        return res;
    endfunction

    task automatic apply_request(input t_in_item rq);
        case (rq.command)
            CMD_TICK:        expected_mix.push_back(render_tick());
            CMD_NOTE_ON: begin
                if (rq.velocity != 0) voice_note_on(rq.note, rq.velocity);
                else voice_note_off(rq.note);
            end
            CMD_NOTE_OFF:    voice_note_off(rq.note);
            CMD_WRITE_FRAME: frame_mem[rq.frame_address] = {rq.right_in, rq.left_in};
            CMD_WRITE_SLICE: begin
                if (rq.slice_number <= 128) slice_starts[rq.slice_number] = rq.slice_frame;
            end
            default: ;
        endcase
    endtask

    // driver: acceptance at the rising edge, new request at the falling edge
    always @(posedge i_clk) begin
        if (started && i_valid && !o_stall) begin
            apply_request(i_in_data);
            took = 1'b1;
            send_idle = draw_wait();
        end
    end

    always @(negedge i_clk) begin
        if (started && (!i_valid || took)) begin
            took = 1'b0;
            if (send_idle > 0) begin
                send_idle--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                i_in_data <= pending_requests.pop_front();
                i_valid   <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (started && o_valid && !i_stall) begin
            recv_idle = draw_wait();
            if (expected_mix.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, o_out_data);
                errors++;
            end else begin
                want = expected_mix.pop_front();
                if (o_out_data.left_out !== want.left_out) begin
                    $display("%0t left_out expected %0d actual %0d", $realtime,
                             want.left_out, o_out_data.left_out);
                    errors++;
                end
                if (o_out_data.right_out !== want.right_out) begin
                    $display("%0t right_out expected %0d actual %0d", $realtime,
                             want.right_out, o_out_data.right_out);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (started && recv_idle > 0) begin
            recv_idle--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_in_item make_req(input logic [2:0] cmd);
        t_in_item rq;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        rq = raw[$bits(t_in_item)-1:0];
        rq.command = cmd;
        return rq;
    endfunction

    task automatic queue_frame(input int addr);
        t_in_item rq;
        rq = make_req(CMD_WRITE_FRAME);
        rq.frame_address = addr[15:0];
        case ($urandom_range(0, 9))
            0: begin rq.left_in = 16'sh7FFF; rq.right_in = 16'sh8000; end
            1: begin rq.left_in = 16'sh8000; rq.right_in = 16'sh7FFF; end
            default: ;
        endcase
        gen_written[addr] = 1'b1;
        pending_requests.push_back(rq);
    endtask

    task automatic queue_slice(input int sn, input int fr);
        t_in_item rq;
        rq = make_req(CMD_WRITE_SLICE);
        rq.slice_number = sn[7:0];
        rq.slice_frame  = fr[16:0];
        if (sn <= 128) begin
            gen_slice[sn] = fr;
            gen_slice_set[sn] = 1'b1;
        end
        pending_requests.push_back(rq);
    endtask

    task automatic queue_note_off(input int nt, input logic [2:0] cmd);
        t_in_item rq;
        rq = make_req(cmd);
        rq.note = nt[6:0];
        rq.velocity = 7'd0;
        pending_requests.push_back(rq);
    endtask

    // only start notes whose slice bounds and frames have been written
    task automatic queue_note_on(input int nt, input int vel);
        t_in_item rq;
        int n;
        int idx;
        int s;
        int e;
        int missing;
        rq = make_req(CMD_NOTE_ON);
        rq.note = nt[6:0];
        rq.velocity = vel[6:0];
        if (vel != 0 && gen_slices_in_use != 0) begin
            n = gen_slices_in_use > 128 ? 128 : gen_slices_in_use;
            idx = nt % n;
            if (!gen_slice_set[idx] || !gen_slice_set[idx + 1]) return;
            s = gen_slice[idx];
            e = gen_slice[idx + 1] > 65536 ? 65536 : gen_slice[idx + 1];
            missing = 0;
            for (int a = s; a < e; a++) if (!gen_written[a]) missing++;
            if (missing > 40) return;
            for (int a = s; a < e; a++) if (!gen_written[a]) queue_frame(a);
            recent_notes.push_back(nt);
            if (recent_notes.size() > 12) void'(recent_notes.pop_front());
        end
        pending_requests.push_back(rq);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RATE_STEP:     cfg_shadow.rate_step = val[18:0];
            REG_ATTACK_COEFF:  cfg_shadow.attack_coeff = val;
            REG_DECAY_COEFF:   cfg_shadow.decay_coeff = val;
            REG_GAIN:          cfg_shadow.gain = val[15:0];
            REG_GATE_MODE:     cfg_shadow.gate_mode = val[0];
            REG_SLICES_IN_USE: begin
                cfg_shadow.slices_in_use = val[7:0];
                gen_slices_in_use = val[7:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_mix.size() != 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic lay_out_slices(input int base, input int max_len);
        int n;
        int f;
        n = gen_slices_in_use > 128 ? 128 : gen_slices_in_use;
        f = base;
        for (int k = 0; k <= n; k++) begin
            if (f > 65536) f = 65536;
            queue_slice(k, f);
            f += $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, max_len);
        end
    endtask

    task automatic random_requests(input int count);
        int n;
        int r;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) == 0) quiet = !quiet;
            r = $urandom_range(0, 99);
            n = gen_slices_in_use > 128 ? 128 : gen_slices_in_use;
            if (r < 45) begin
                pending_requests.push_back(make_req(CMD_TICK));
            end else if (r < 75) begin
                queue_note_on($urandom_range(0, 127),
                              $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 127));
            end else if (r < 85) begin
                if (recent_notes.size() > 0 && $urandom_range(0, 3) != 0)
                    queue_note_off(recent_notes[$urandom_range(0, recent_notes.size() - 1)],
                                   CMD_NOTE_OFF);
                else
                    queue_note_off($urandom_range(0, 127), CMD_NOTE_OFF);
            end else if (r < 92) begin
                queue_frame($urandom_range(0, 65535));
            end else if (r < 96) begin
                if (n > 0) begin
                    r = $urandom_range(1, n);
                    if (gen_slice_set[r - 1]) queue_slice(r, gen_slice[r - 1] + $urandom_range(0, 12));
                end
            end else if (r < 98) begin
                pending_requests.push_back(make_req(3'($urandom_range(5, 7))));
            end else begin
                queue_slice($urandom_range(129, 255), $urandom_range(0, 65536));
            end
        end
    endtask

    task automatic random_config(input int siu);
        logic [24:0] v;
        case ($urandom_range(0, 3))
            0: v = 25'd16384;
            1: v = 25'd262144;
            default: v = 25'($urandom_range(16384, 262144));
        endcase
        write_reg(REG_RATE_STEP, v);
        case ($urandom_range(0, 4))
            0: v = 25'd0;
            1: v = 25'd16777216;
            2: v = 25'h1FFFFFF;
            default: v = 25'($urandom_range(15000000, 16777215));
        endcase
        write_reg(REG_ATTACK_COEFF, v);
        case ($urandom_range(0, 4))
            0: v = 25'd0;
            1: v = 25'd16777216;
            2: v = 25'h1FFFFFF;
            default: v = 25'($urandom_range(15000000, 16777215));
        endcase
        write_reg(REG_DECAY_COEFF, v);
        case ($urandom_range(0, 3))
            0: v = 25'd0;
            1: v = 25'd65535;
            default: v = 25'($urandom_range(0, 65535));
        endcase
        write_reg(REG_GAIN, v);
        write_reg(REG_GATE_MODE, 25'($urandom_range(0, 1)));
        write_reg(REG_SLICES_IN_USE, 25'(siu));
    endtask

    initial begin
        int siu_list [10] = '{1, 2, 7, 128, 200, 0, 16, 3, 64, 255};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in_data   = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        errors = 0;
        started = 1'b0;
        quiet = 1'b0;
        took = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        cfg_shadow = '{RST_RATE_STEP, RST_ATTACK_COEFF, RST_DECAY_COEFF, RST_GAIN, 1'b0, 8'd0};
        gen_slices_in_use = 0;
        for (int i = 0; i < 8; i++) begin
            vc_active[i] = 1'b0; vc_note[i] = '0; vc_pos[i] = 0; vc_rate[i] = '0;
            vc_end[i] = '0; vc_phase[i] = PH_IDLE; vc_env[i] = 0; vc_att[i] = '0;
            vc_dec[i] = '0; vc_vel[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        started = 1'b1;

        // reset settings: no slices, so notes start nothing
        pending_requests.push_back(make_req(CMD_TICK));
        queue_note_on(5, 127);
        pending_requests.push_back(make_req(3'd5));
        pending_requests.push_back(make_req(3'd7));
        queue_slice(200, 65536);
        pending_requests.push_back(make_req(CMD_TICK));
        wait_drained();

        // directed: empty slice, slice at the top of memory, samples that may take extreme values
        write_reg(REG_ATTACK_COEFF, 25'd16777216);
        write_reg(REG_GATE_MODE, 25'd1);
        write_reg(REG_SLICES_IN_USE, 25'd4);
        queue_slice(0, 0);
        queue_slice(1, 3);
        queue_slice(2, 65534);
        queue_slice(3, 65536);
        queue_slice(4, 65536);
        queue_frame(65535);
        queue_note_on(0, 127);
        queue_note_on(2, 1);
        queue_note_on(3, 127);
        queue_note_on(127, 127);
        repeat (3) pending_requests.push_back(make_req(CMD_TICK));
        queue_note_on(0, 0);
        queue_note_off(2, CMD_NOTE_OFF);
        repeat (4) pending_requests.push_back(make_req(CMD_TICK));
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            random_config(siu_list[ph]);
            if (siu_list[ph] >= 128 && ph < 5)
                lay_out_slices(65536 - 129 * 2, 2);
            else if (siu_list[ph] != 0)
                lay_out_slices($urandom_range(0, 60000), 16);
            random_requests(75);
            wait_drained();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
